[hw/rtl/spring_length_clamp_correction_macros.svh]
// Assertion helpers used by the top-level RTL file.
`ifndef SPRING_LENGTH_CLAMP_CORRECTION_MACROS_SVH
`define SPRING_LENGTH_CLAMP_CORRECTION_MACROS_SVH

// same-cycle implication, checked out of reset
`define SLCC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("slcc assertion failed");

// next-cycle implication, checked out of reset
`define SLCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("slcc assertion failed");

`endif

[hw/rtl/slcc_pkg.sv]
`timescale 1ns / 1ps

package slcc_pkg;

    localparam int POS_W     = 24;
    localparam int LANES     = 3;
    localparam int DLT_W     = POS_W + 1;
    localparam int LEN_W     = POS_W + 2;
    localparam int DIST_W    = POS_W + 1;
    localparam int SQ_W      = 2 * DIST_W;
    localparam int DEN_W     = POS_W + 2;
    localparam int QUO_W     = POS_W + 2;
    localparam int NUM_W     = DLT_W + LEN_W;
    localparam int RATIO_W   = 16;
    localparam int FRAC_W    = 14;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH  = 2'd1;

    localparam logic [RATIO_W-1:0] COMPRESS_RST = 16'd14746;
    localparam logic [RATIO_W-1:0] STRETCH_RST  = 16'd18022;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [DLT_W-1:0] t_dlt;

    typedef struct packed {
        logic signed [POS_W-1:0] a_x;
        logic signed [POS_W-1:0] a_y;
        logic signed [POS_W-1:0] a_z;
        logic signed [POS_W-1:0] b_x;
        logic signed [POS_W-1:0] b_y;
        logic signed [POS_W-1:0] b_z;
        logic [POS_W-1:0]        rest_length;
        logic                    a_pinned;
        logic                    b_pinned;
    } t_in;

    typedef struct packed {
        logic signed [POS_W-1:0] new_a_x;
        logic signed [POS_W-1:0] new_a_y;
        logic signed [POS_W-1:0] new_a_z;
        logic signed [POS_W-1:0] new_b_x;
        logic signed [POS_W-1:0] new_b_y;
        logic signed [POS_W-1:0] new_b_z;
        logic                    was_corrected;
    } t_out;

    // carried alongside the square root
    typedef struct packed {
        t_pos [LANES-1:0] a;
        t_pos [LANES-1:0] b;
        t_dlt [LANES-1:0] d;
        logic [LEN_W-1:0] min_len;
        logic [LEN_W-1:0] max_len;
        logic             a_pinned;
        logic             b_pinned;
    } t_sq_side;

    // carried alongside the divider
    typedef struct packed {
        t_pos [LANES-1:0] a;
        t_pos [LANES-1:0] b;
        logic [LANES-1:0] neg;
        logic             hit;
        logic             a_pinned;
        logic             b_pinned;
    } t_div_side;

endpackage

[hw/rtl/slcc_isqrt.sv]
`timescale 1ns / 1ps

module slcc_isqrt (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [slcc_pkg::SQ_W-1:0]   i_rad,
    input  slcc_pkg::t_sq_side       i_side,
    output logic                     o_valid,
    output logic [slcc_pkg::DIST_W-1:0] o_dist,
    output slcc_pkg::t_sq_side       o_side
);
    import slcc_pkg::*;

    localparam int STEPS = DIST_W;

    logic              r_v    [0:STEPS-1];
    logic [DIST_W:0]   r_rem  [0:STEPS-1];
    logic [DIST_W-1:0] r_root [0:STEPS-1];
    logic [SQ_W-1:0]   r_rad  [0:STEPS-1];
    t_sq_side          r_side [0:STEPS-1];

    // one result bit per stage, two radicand bits consumed per stage
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic              v_in;
        logic [DIST_W:0]   rem_in;
        logic [DIST_W-1:0] root_in;
        logic [SQ_W-1:0]   rad_in;
        t_sq_side          side_in;
        logic [DIST_W+2:0] cat;
        logic [DIST_W+2:0] trial;
        logic [DIST_W+2:0] diff;
        logic              ge;
        logic [DIST_W:0]   n_rem;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign side_in = r_side[k-1];
        end

        assign cat   = {rem_in, rad_in[SQ_W-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = (cat >= trial);
        assign diff  = cat - trial;
        assign n_rem = ge ? diff[DIST_W:0] : cat[DIST_W:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= {root_in[DIST_W-2:0], ge};
                r_rad[k]  <= {rad_in[SQ_W-3:0], 2'b00};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_dist  = r_root[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

[hw/rtl/slcc_div.sv]
`timescale 1ns / 1ps

module slcc_div (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_en,
    input  logic                                         i_valid,
    input  logic [slcc_pkg::LANES-1:0][slcc_pkg::NUM_W-1:0] i_num,
    input  logic [slcc_pkg::DEN_W-1:0]                   i_den,
    input  slcc_pkg::t_div_side                          i_side,
    output logic                                         o_valid,
    output logic [slcc_pkg::LANES-1:0][slcc_pkg::QUO_W-1:0] o_quo,
    output slcc_pkg::t_div_side                          o_side
);
    import slcc_pkg::*;

    localparam int STEPS = QUO_W;
    localparam int TOP_W = NUM_W - QUO_W;

    logic                               r_v    [0:STEPS-1];
    logic [LANES-1:0][DEN_W-1:0]        r_rem  [0:STEPS-1];
    logic [LANES-1:0][QUO_W-1:0]        r_lq   [0:STEPS-1];
    logic [DEN_W-1:0]                   r_den  [0:STEPS-1];
    t_div_side                          r_side [0:STEPS-1];

    // restoring division, one quotient bit per stage; the low dividend bits
    // shift out of the top of r_lq while quotient bits shift in below
    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic                        v_in;
        logic [LANES-1:0][DEN_W-1:0] rem_in;
        logic [LANES-1:0][QUO_W-1:0] lq_in;
        logic [DEN_W-1:0]            den_in;
        t_div_side                   side_in;
        logic [LANES-1:0][DEN_W-1:0] n_rem;
        logic [LANES-1:0][QUO_W-1:0] n_lq;

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    rem_in[l] = {{(DEN_W-TOP_W){1'b0}}, i_num[l][NUM_W-1:QUO_W]};
                    lq_in[l]  = i_num[l][QUO_W-1:0];
                end
            end
            assign v_in    = i_valid;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign lq_in   = r_lq[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        always_comb begin
            logic [DEN_W:0] cat;
            logic [DEN_W:0] dif;
            logic           ge;
            for (int l = 0; l < LANES; l++) begin
                cat      = {rem_in[l], lq_in[l][QUO_W-1]};
                dif      = cat - {1'b0, den_in};
                ge       = (cat >= {1'b0, den_in});
                n_rem[l] = ge ? dif[DEN_W-1:0] : cat[DEN_W-1:0];
                n_lq[l]  = {lq_in[l][QUO_W-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_lq[k]   <= n_lq;
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_quo   = r_lq[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

[hw/rtl/spring_length_clamp_correction.sv]
`timescale 1ns / 1ps
// Spring length clamp for a mass-spring cloth stretch constraint.
// Input channel: i_in_valid / o_in_stall carry one spring (both end points,
// rest length, pin flags) in i_in_data. Output channel: o_out_valid /
// i_out_stall carry the corrected end points and the was_corrected flag.
// Config: i_cfg_we writes compress_ratio (index 0) or stretch_ratio (index 1)
// from i_cfg_data; other indexes are ignored. Write only while idle.
// Throughput: one spring per cycle while o_in_stall is low. The pipeline is
// the difference, square and sum stages, the square root pipeline (one root
// bit per stage), the clamp and product stages, the divider pipeline (one
// quotient bit per stage, three lanes side by side) and the output stage.
// Reset: synchronous, active low; clears all stage valids and loads the
// ratio registers with their defaults.
// Stall: the output register holds while it is valid and i_out_stall is high;
// the whole pipeline freezes with it and o_in_stall is raised, so nothing is lost or
// repeated. A new spring is taken whenever the output is free or drained.
`include "spring_length_clamp_correction_macros.svh"

module spring_length_clamp_correction (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  slcc_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output slcc_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_we,
    input  logic [slcc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [slcc_pkg::RATIO_W-1:0]       i_cfg_data
);
    import slcc_pkg::*;

    localparam int SUM_W  = POS_W + 4;
    localparam int PROD_W = POS_W + RATIO_W;

    function automatic t_pos sat_pos(input logic signed [SUM_W-1:0] v);
        if (&v[SUM_W-1:POS_W-1] || ~|v[SUM_W-1:POS_W-1]) begin
            return v[POS_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end
    endfunction

    logic en;

    logic [RATIO_W-1:0] r_compress;
    logic [RATIO_W-1:0] r_stretch;

    // stage 1: differences
    t_pos [LANES-1:0]            in_a;
    t_pos [LANES-1:0]            in_b;
    t_sq_side                    n_s1_side;
    logic [LANES-1:0][DLT_W-1:0] n_s1_mag;
    logic                        r_s1_v;
    t_sq_side                    r_s1_side;
    logic [LANES-1:0][DLT_W-1:0] r_s1_mag;
    logic [POS_W-1:0]            r_s1_rest;

    // stage 2: squares and length limits
    logic [LANES-1:0][SQ_W-1:0]  n_s2_sq;
    logic [PROD_W-1:0]           prod_min;
    logic [PROD_W-1:0]           prod_max;
    t_sq_side                    n_s2_side;
    logic                        r_s2_v;
    logic [LANES-1:0][SQ_W-1:0]  r_s2_sq;
    t_sq_side                    r_s2_side;

    // stage 3: squared length
    logic                        r_s3_v;
    logic [SQ_W-1:0]             r_s3_sum;
    t_sq_side                    r_s3_side;

    // square root
    logic                        sq_v;
    logic [DIST_W-1:0]           sq_dist;
    t_sq_side                    sq_side;

    // stage 4: clamp
    logic [LEN_W-1:0]            dist_x;
    logic [LEN_W-1:0]            lo_c;
    logic [LEN_W-1:0]            target;
    logic                        n_s4_hit;
    logic                        n_s4_neg;
    logic [LEN_W-1:0]            n_s4_dmag;
    logic [DEN_W-1:0]            n_s4_den;
    logic                        r_s4_v;
    t_sq_side                    r_s4_side;
    logic                        r_s4_hit;
    logic                        r_s4_neg;
    logic [LEN_W-1:0]            r_s4_dmag;
    logic [DEN_W-1:0]            r_s4_den;

    // stage 5: dividends
    logic [LANES-1:0][NUM_W-1:0] n_s5_num;
    t_div_side                   n_s5_side;
    logic                        r_s5_v;
    logic [LANES-1:0][NUM_W-1:0] r_s5_num;
    logic [DEN_W-1:0]            r_s5_den;
    t_div_side                   r_s5_side;

    // divider
    logic                        dv_v;
    logic [LANES-1:0][QUO_W-1:0] dv_quo;
    t_div_side                   dv_side;

    // output
    t_pos [LANES-1:0]            n_new_a;
    t_pos [LANES-1:0]            n_new_b;
    t_out                        n_out;
    logic                        r_out_v;
    t_out                        r_out;

    // the whole pipeline moves unless the output holds a stalled transfer
    assign en          = !(r_out_v && i_out_stall);
    assign o_in_stall  = r_out_v && i_out_stall;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compress <= COMPRESS_RST;
            r_stretch  <= STRETCH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_COMPRESS: r_compress <= i_cfg_data;
                CFG_STRETCH:  r_stretch  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign in_a[0] = i_in_data.a_x;
    assign in_a[1] = i_in_data.a_y;
    assign in_a[2] = i_in_data.a_z;
    assign in_b[0] = i_in_data.b_x;
    assign in_b[1] = i_in_data.b_y;
    assign in_b[2] = i_in_data.b_z;

    always_comb begin
        t_dlt dl;
        n_s1_side          = '0;
        n_s1_side.a        = in_a;
        n_s1_side.b        = in_b;
        n_s1_side.a_pinned = i_in_data.a_pinned;
        n_s1_side.b_pinned = i_in_data.b_pinned;
        for (int l = 0; l < LANES; l++) begin
            dl = DLT_W'($signed(in_b[l])) - DLT_W'($signed(in_a[l]));
            n_s1_side.d[l] = dl;
            n_s1_mag[l]    = dl[DLT_W-1] ? DLT_W'(-dl) : DLT_W'(dl);
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_s2_sq[l] = r_s1_mag[l] * r_s1_mag[l];
        end
        prod_min          = r_s1_rest * r_compress;
        prod_max          = r_s1_rest * r_stretch;
        n_s2_side         = r_s1_side;
        n_s2_side.min_len = prod_min[PROD_W-1:FRAC_W];
        n_s2_side.max_len = prod_max[PROD_W-1:FRAC_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_in_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side <= n_s1_side;
            r_s1_mag  <= n_s1_mag;
            r_s1_rest <= i_in_data.rest_length;
            r_s2_sq   <= n_s2_sq;
            r_s2_side <= n_s2_side;
            r_s3_sum  <= r_s2_sq[0] + r_s2_sq[1] + r_s2_sq[2];
            r_s3_side <= r_s2_side;
        end
    end

    slcc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s3_v),
        .i_rad   (r_s3_sum),
        .i_side  (r_s3_side),
        .o_valid (sq_v),
        .o_dist  (sq_dist),
        .o_side  (sq_side)
    );

    always_comb begin
        dist_x    = {1'b0, sq_dist};
        n_s4_hit  = (sq_dist != '0) &&
                    ((dist_x < sq_side.min_len) || (dist_x > sq_side.max_len));
        lo_c      = (dist_x < sq_side.min_len) ? sq_side.min_len : dist_x;
        target    = (lo_c > sq_side.max_len) ? sq_side.max_len : lo_c;
        n_s4_neg  = dist_x < target;
        n_s4_dmag = n_s4_neg ? target - dist_x : dist_x - target;
        // both ends move: each takes the same half, truncated once
        n_s4_den  = (!sq_side.a_pinned && !sq_side.b_pinned) ? {sq_dist, 1'b0}
                                                              : {1'b0, sq_dist};
    end

    always_comb begin
        logic [DLT_W-1:0] mg;
        n_s5_side          = '0;
        n_s5_side.a        = r_s4_side.a;
        n_s5_side.b        = r_s4_side.b;
        n_s5_side.hit      = r_s4_hit;
        n_s5_side.a_pinned = r_s4_side.a_pinned;
        n_s5_side.b_pinned = r_s4_side.b_pinned;
        for (int l = 0; l < LANES; l++) begin
            mg = r_s4_side.d[l][DLT_W-1] ? DLT_W'(-r_s4_side.d[l]) : DLT_W'(r_s4_side.d[l]);
            n_s5_num[l]      = mg * r_s4_dmag;
            n_s5_side.neg[l] = r_s4_side.d[l][DLT_W-1] ^ r_s4_neg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= sq_v;
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_side <= sq_side;
            r_s4_hit  <= n_s4_hit;
            r_s4_neg  <= n_s4_neg;
            r_s4_dmag <= n_s4_dmag;
            r_s4_den  <= n_s4_den;
            r_s5_num  <= n_s5_num;
            r_s5_den  <= r_s4_den;
            r_s5_side <= n_s5_side;
        end
    end

    slcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s5_v),
        .i_num   (r_s5_num),
        .i_den   (r_s5_den),
        .i_side  (r_s5_side),
        .o_valid (dv_v),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    always_comb begin
        logic signed [QUO_W:0]   c;
        logic signed [SUM_W-1:0] ce;
        logic signed [SUM_W-1:0] sa;
        logic signed [SUM_W-1:0] sb;
        for (int l = 0; l < LANES; l++) begin
            c  = dv_side.neg[l] ? -$signed({1'b0, dv_quo[l]}) : $signed({1'b0, dv_quo[l]});
            ce = dv_side.hit ? SUM_W'(c) : '0;
            sa = SUM_W'($signed(dv_side.a[l]));
            sb = SUM_W'($signed(dv_side.b[l]));
            if (!dv_side.a_pinned) begin
                sa = sa + ce;
            end
            if (!dv_side.b_pinned) begin
                sb = sb - ce;
            end
            n_new_a[l] = sat_pos(sa);
            n_new_b[l] = sat_pos(sb);
        end
        n_out.new_a_x       = n_new_a[0];
        n_out.new_a_y       = n_new_a[1];
        n_out.new_a_z       = n_new_a[2];
        n_out.new_b_x       = n_new_b[0];
        n_out.new_b_y       = n_new_b[1];
        n_out.new_b_z       = n_new_b[2];
        n_out.was_corrected = dv_side.hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    `SLCC_ASSERT_SAME(a_stall_needs_full_out, o_in_stall, o_out_valid)
    `SLCC_ASSERT_NEXT(a_freeze_holds_front, o_in_stall, $stable(r_s1_v))
    `SLCC_ASSERT_SAME(a_hit_has_divisor, r_s4_v && r_s4_hit, r_s4_den != '0)

endmodule
